### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the density summation unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sdses_pkg.sv
// Types, constants and codes of the density summation and error statistics unit.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps
package sdses_pkg;

    localparam int MAX_PARTICLES = 65536;
    localparam int MAX_NEIGHBORS = 64;
    localparam int TALLY_W = 17;
    localparam int TALLY_CAP_I = (MAX_PARTICLES < 131071) ? MAX_PARTICLES : 131071;
    localparam logic [TALLY_W-1:0] TALLY_CAP = TALLY_W'(TALLY_CAP_I);
    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam logic [CNT_W-1:0] NEIGHBOR_CAP = CNT_W'(MAX_NEIGHBORS);
    localparam int ACC_W = 48;
    localparam int DIV_W = 48;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] REST_DENSITY_RST = 32'd65536000;
    localparam logic [31:0] PERCENT_SCALE_RST = 32'd1677722;
    localparam logic [31:0] UPPER_HEIGHT_RST = 32'h7FFF_FFFF;
    localparam logic [31:0] LOWER_HEIGHT_RST = 32'h8000_0000;
    localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0080_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REST_DENSITY     = 3'd0,
        CFG_PERCENT_SCALE    = 3'd1,
        CFG_UPPER_HEIGHT     = 3'd2,
        CFG_LOWER_HEIGHT     = 3'd3,
        CFG_WHOLE_FLUID_MODE = 3'd4,
        CFG_ABS_ERROR_MODE   = 3'd5,
        CFG_DIVIDE_BY_FLUID  = 3'd6,
        CFG_FLUID_COUNT      = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_EVAL,
        S_EMUL,
        S_ESUM,
        S_DSTART,
        S_DIV
    } t_state;

    typedef struct packed {
        logic [31:0]        kernel_value;
        logic [31:0]        particle_mass;
        logic signed [31:0] height;
        logic               is_boundary;
        logic               is_floating;
        logic               is_moving;
        logic [15:0]        particle_id;
        logic               last_neighbor;
        logic               last_particle;
    } t_item;

    typedef struct packed {
        logic [31:0]        density;
        logic [15:0]        result_id;
        logic               selected;
        logic               too_low;
        logic signed [31:0] error_average;
        logic [16:0]        above_count;
        logic               stats_valid;
        logic               divide_fault;
    } t_result;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic acc;
        logic eval;
        logic emul;
        logic esum;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_n;
        logic last_p;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/sdses_if.sv
// Valid/ready channel interfaces for input items and result items.
// No dependencies; field widths match t_item/t_result in sdses_pkg.
`timescale 1ns / 1ps
interface sdses_item_if;
    logic               valid;
    logic               ready;
    logic [31:0]        kernel_value;
    logic [31:0]        particle_mass;
    logic signed [31:0] height;
    logic               is_boundary;
    logic               is_floating;
    logic               is_moving;
    logic [15:0]        particle_id;
    logic               last_neighbor;
    logic               last_particle;

    modport source (
        output valid, kernel_value, particle_mass, height, is_boundary, is_floating,
               is_moving, particle_id, last_neighbor, last_particle,
        input  ready
    );
    modport sink (
        input  valid, kernel_value, particle_mass, height, is_boundary, is_floating,
               is_moving, particle_id, last_neighbor, last_particle,
        output ready
    );
endinterface

interface sdses_result_if;
    logic               valid;
    logic               ready;
    logic [31:0]        density;
    logic [15:0]        result_id;
    logic               selected;
    logic               too_low;
    logic signed [31:0] error_average;
    logic [16:0]        above_count;
    logic               stats_valid;
    logic               divide_fault;

    modport source (
        output valid, density, result_id, selected, too_low, error_average,
               above_count, stats_valid, divide_fault,
        input  ready
    );
    modport sink (
        input  valid, density, result_id, selected, too_low, error_average,
               above_count, stats_valid, divide_fault,
        output ready
    );
endinterface

### rtl/core/sph_density_sum_error_stats_unit.sv
// Top level of the density summation and error statistics unit.
// Depends on sdses_pkg, sdses_if, sdses_ctrl, sdses_datapath, assert_macros.svh.
//
//   channel    direction  transaction
//   i_item     in         one neighbour kernel weight with particle fields
//   o_result   out        one particle result, on the item with last_neighbor
//   i_cfg_*    in         register write, index selects register
//
// Without last_neighbor an item is accepted, multiplied and accumulated. With it,
// evaluation, error multiply, error sum and result load follow, and on last_particle
// the bit-serial divider runs first. Reset restores control, tallies, sums and config.
// A result waits in the output register; the next item is accepted meanwhile,
// and a following result holds in the sequencer until that register is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sph_density_sum_error_stats_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sdses_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sdses_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sdses_item_if.sink                       i_item,
    sdses_result_if.source                   o_result
);
    sdses_pkg::t_item   w_item;
    sdses_pkg::t_result w_res;
    sdses_pkg::t_cmd    w_cmd;
    sdses_pkg::t_stat   w_stat;
    sdses_pkg::t_state  w_state;
    logic               w_out_valid;

    assign w_item.kernel_value  = i_item.kernel_value;
    assign w_item.particle_mass = i_item.particle_mass;
    assign w_item.height        = i_item.height;
    assign w_item.is_boundary   = i_item.is_boundary;
    assign w_item.is_floating   = i_item.is_floating;
    assign w_item.is_moving     = i_item.is_moving;
    assign w_item.particle_id   = i_item.particle_id;
    assign w_item.last_neighbor = i_item.last_neighbor;
    assign w_item.last_particle = i_item.last_particle;

    sdses_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_item.ready),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    sdses_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .i_out_ready (o_result.ready),
        .o_stat      (w_stat),
        .o_out_valid (w_out_valid),
        .o_result    (w_res)
    );

    assign o_result.valid         = w_out_valid;
    assign o_result.density       = w_res.density;
    assign o_result.result_id     = w_res.result_id;
    assign o_result.selected      = w_res.selected;
    assign o_result.too_low       = w_res.too_low;
    assign o_result.error_average = w_res.error_average;
    assign o_result.above_count   = w_res.above_count;
    assign o_result.stats_valid   = w_res.stats_valid;
    assign o_result.divide_fault  = w_res.divide_fault;

    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, w_cmd.out_load, w_stat.out_free, "result overwritten while held")
    `ASSERT_IMPL(a_idle_div, i_clk, i_rst_n, w_state == sdses_pkg::S_IDLE, !w_stat.div_busy, "divider busy while idle")
    `ASSERT_IMPL(a_stats_zero, i_clk, i_rst_n, o_result.valid && !o_result.stats_valid, (o_result.error_average == '0) && !o_result.divide_fault, "average outside last particle")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready, "accepted while item in work")
endmodule

### rtl/core/sdses_div.sv
// Restoring divider, one quotient bit per cycle, for the pass error average.
// Depends on sdses_pkg for widths.
`timescale 1ns / 1ps
module sdses_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [sdses_pkg::DIV_W-1:0]        i_dividend,
    input  logic [sdses_pkg::TALLY_W-1:0]      i_divisor,
    output logic                               o_busy,
    output logic [sdses_pkg::DIV_W-1:0]        o_quotient
);
    logic [sdses_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                            r_busy, n_busy;
    logic [sdses_pkg::DIV_W-1:0]     r_quo, n_quo;
    logic [sdses_pkg::TALLY_W-1:0]   r_rem, n_rem;
    logic [sdses_pkg::TALLY_W-1:0]   r_dvs, n_dvs;
    logic [sdses_pkg::TALLY_W:0]     w_trial;
    logic                            w_fit;

    assign w_trial = {r_rem, r_quo[sdses_pkg::DIV_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_cnt  = sdses_pkg::DIV_CNT_W'(sdses_pkg::DIV_W);
            n_busy = 1'b1;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[sdses_pkg::DIV_W-2:0], w_fit};
            n_rem = w_fit ? sdses_pkg::TALLY_W'(w_trial - {1'b0, r_dvs})
                          : sdses_pkg::TALLY_W'(w_trial);
            n_cnt = r_cnt - sdses_pkg::DIV_CNT_W'(1);
            if (r_cnt == sdses_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

### rtl/core/sdses_datapath.sv
// Datapath: configuration registers, density accumulator, error sum, tallies,
// result register. Depends on sdses_pkg and instantiates sdses_div.
`timescale 1ns / 1ps
module sdses_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdses_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sdses_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  sdses_pkg::t_item                    i_item,
    input  sdses_pkg::t_cmd                     i_cmd,
    input  logic                                i_out_ready,
    output sdses_pkg::t_stat                    o_stat,
    output logic                                o_out_valid,
    output sdses_pkg::t_result                  o_result
);
    // configuration
    logic [31:0]        r_rest, r_scale;
    logic signed [31:0] r_upper, r_lower;
    logic               r_whole, r_abs, r_by_fluid;
    logic [16:0]        r_fluid_cnt;

    // latched item
    sdses_pkg::t_item   r_item;

    // per-particle and per-pass state
    logic [63:0]                       r_prod;
    logic [sdses_pkg::ACC_W-1:0]       r_acc, n_acc;
    logic [sdses_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [31:0]                       r_dens, r_diff;
    logic                              r_sel, r_high, r_neg;
    logic [63:0]                       r_eprod;
    logic signed [47:0]                r_sum, n_sum;
    logic [sdses_pkg::TALLY_W-1:0]     r_above, n_above, r_seltal, n_seltal;
    logic                              r_out_valid, n_out_valid;
    sdses_pkg::t_result                r_res, n_res;

    logic [sdses_pkg::ACC_W:0]         w_acc_sum;
    logic [31:0]                       w_dens_sat, w_dens;
    logic                              w_win, w_high, w_sel, w_neg;
    logic [63:0]                       w_rnd;
    logic [39:0]                       w_mag;
    logic signed [40:0]                w_e;
    logic signed [49:0]                w_sum_ext;
    logic [47:0]                       w_abs_sum;
    logic [sdses_pkg::TALLY_W-1:0]     w_divisor;
    logic                              w_fault;
    logic                              w_div_busy;
    logic [sdses_pkg::DIV_W-1:0]       w_quo;
    logic signed [31:0]                w_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest      <= sdses_pkg::REST_DENSITY_RST;
            r_scale     <= sdses_pkg::PERCENT_SCALE_RST;
            r_upper     <= sdses_pkg::UPPER_HEIGHT_RST;
            r_lower     <= sdses_pkg::LOWER_HEIGHT_RST;
            r_whole     <= 1'b0;
            r_abs       <= 1'b0;
            r_by_fluid  <= 1'b0;
            r_fluid_cnt <= '0;
        end else if (i_cfg_we) begin
            unique case (sdses_pkg::t_cfg_idx'(i_cfg_idx))
                sdses_pkg::CFG_REST_DENSITY:     r_rest      <= i_cfg_data;
                sdses_pkg::CFG_PERCENT_SCALE:    r_scale     <= i_cfg_data;
                sdses_pkg::CFG_UPPER_HEIGHT:     r_upper     <= i_cfg_data;
                sdses_pkg::CFG_LOWER_HEIGHT:     r_lower     <= i_cfg_data;
                sdses_pkg::CFG_WHOLE_FLUID_MODE: r_whole     <= i_cfg_data[0];
                sdses_pkg::CFG_ABS_ERROR_MODE:   r_abs       <= i_cfg_data[0];
                sdses_pkg::CFG_DIVIDE_BY_FLUID:  r_by_fluid  <= i_cfg_data[0];
                sdses_pkg::CFG_FLUID_COUNT:      r_fluid_cnt <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // accumulate kernel times mass, saturating
    assign w_acc_sum = {1'b0, r_acc} + {1'b0, r_prod[63:16]};

    // evaluate the finished particle
    assign w_dens_sat = (r_acc > sdses_pkg::ACC_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                  : r_acc[31:0];
    assign w_dens = r_item.is_boundary ? r_rest : w_dens_sat;
    assign w_win  = (r_item.height < r_upper) && (r_item.height > r_lower);
    assign w_high = w_dens >= r_rest;
    assign w_neg  = w_dens < r_rest;
    assign w_sel  = !r_item.is_boundary && w_win && !r_item.is_floating
                    && !r_item.is_moving && (r_whole || w_high);

    // percent error, rounded half away from zero on the magnitude
    assign w_rnd     = r_eprod + sdses_pkg::ROUND_HALF;
    assign w_mag     = w_rnd[63:24];
    assign w_e       = (r_neg && !r_abs) ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    assign w_sum_ext = {{2{r_sum[47]}}, r_sum} + {{9{w_e[40]}}, w_e};

    // pass average
    assign w_abs_sum = r_sum[47] ? 48'(-r_sum) : 48'(r_sum);
    assign w_divisor = r_by_fluid ? r_fluid_cnt : r_seltal;
    assign w_fault   = w_divisor == '0;

    always_comb begin
        if (r_sum[47]) begin
            w_avg = (w_quo > 48'd2147483648) ? 32'sh8000_0000 : -$signed(w_quo[31:0]);
        end else begin
            w_avg = (w_quo > 48'd2147483647) ? 32'sh7FFF_FFFF : $signed(w_quo[31:0]);
        end
    end

    sdses_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_abs_sum),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_above     = r_above;
        n_seltal    = r_seltal;
        n_out_valid = r_out_valid;
        n_res       = r_res;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.acc && (r_cnt < sdses_pkg::NEIGHBOR_CAP)) begin
            n_acc = w_acc_sum[sdses_pkg::ACC_W] ? '1 : w_acc_sum[sdses_pkg::ACC_W-1:0];
            n_cnt = r_cnt + sdses_pkg::CNT_W'(1);
        end
        if (i_cmd.eval) begin
            n_acc = '0;
            n_cnt = '0;
        end
        if (i_cmd.esum && r_sel) begin
            if (w_sum_ext[49:47] == 3'b000 || w_sum_ext[49:47] == 3'b111) begin
                n_sum = w_sum_ext[47:0];
            end else if (w_sum_ext[49]) begin
                n_sum = 48'sh8000_0000_0000;
            end else begin
                n_sum = 48'sh7FFF_FFFF_FFFF;
            end
            if (r_seltal < sdses_pkg::TALLY_CAP) begin
                n_seltal = r_seltal + sdses_pkg::TALLY_W'(1);
            end
            if (r_high && (r_above < sdses_pkg::TALLY_CAP)) begin
                n_above = r_above + sdses_pkg::TALLY_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            n_out_valid         = 1'b1;
            n_res.density       = r_dens;
            n_res.result_id     = r_item.particle_id;
            n_res.selected      = r_sel;
            n_res.too_low       = !r_sel;
            n_res.above_count   = r_above;
            n_res.stats_valid   = r_item.last_particle;
            n_res.divide_fault  = r_item.last_particle && w_fault;
            n_res.error_average = (r_item.last_particle && !w_fault) ? w_avg : '0;
            if (r_item.last_particle) begin
                n_sum    = '0;
                n_above  = '0;
                n_seltal = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_above     <= '0;
            r_seltal    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_above     <= n_above;
            r_seltal    <= n_seltal;
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
        if (i_cmd.load_in) begin
            r_item <= i_item;
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_item.kernel_value) * 64'(r_item.particle_mass);
        end
        if (i_cmd.eval) begin
            r_dens <= w_dens;
            r_sel  <= w_sel;
            r_high <= w_high;
            r_neg  <= w_neg;
            r_diff <= w_neg ? (r_rest - w_dens) : (w_dens - r_rest);
        end
        if (i_cmd.emul) begin
            r_eprod <= 64'(r_diff) * 64'(r_scale);
        end
    end

    assign o_stat.last_n   = r_item.last_neighbor;
    assign o_stat.last_p   = r_item.last_particle;
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_result        = r_res;
endmodule

### rtl/core/sdses_ctrl.sv
// Controller state machine: sequences accept, multiply, accumulate, error and divide steps.
// Depends on sdses_pkg for state, command and status types.
`timescale 1ns / 1ps
module sdses_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sdses_pkg::t_stat  i_stat,
    output logic              o_in_ready,
    output sdses_pkg::t_cmd   o_cmd,
    output sdses_pkg::t_state o_state
);
    sdses_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdses_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sdses_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = sdses_pkg::S_MUL;
                end
            end
            sdses_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = sdses_pkg::S_ACC;
            end
            sdses_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.last_n ? sdses_pkg::S_EVAL : sdses_pkg::S_IDLE;
            end
            sdses_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = sdses_pkg::S_EMUL;
            end
            sdses_pkg::S_EMUL: begin
                o_cmd.emul = 1'b1;
                n_state    = sdses_pkg::S_ESUM;
            end
            sdses_pkg::S_ESUM: begin
                o_cmd.esum = 1'b1;
                n_state    = i_stat.last_p ? sdses_pkg::S_DSTART : sdses_pkg::S_DIV;
            end
            sdses_pkg::S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = sdses_pkg::S_DIV;
            end
            sdses_pkg::S_DIV: begin
                // hold until the quotient is ready and the result register is free
                if (!i_stat.div_busy && i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sdses_pkg::S_IDLE;
                end
            end
            default: n_state = sdses_pkg::S_IDLE;
        endcase
    end

    assign o_state = r_state;
endmodule

### tb/tb.sv
// Self-checking bench for sph_density_sum_error_stats_unit: particle items in, reports out.
// Depends on sdses_pkg and sdses_if; predicts every report and compares field by field.
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef enum {K_NEAR_REST, K_RANDOM, K_SMALL, K_MAX} t_kern_style;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [sdses_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [sdses_pkg::CFG_DATA_W-1:0] i_cfg_data;

    sdses_item_if   item_bus();
    sdses_result_if result_bus();

    sph_density_sum_error_stats_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_bus),
        .o_result   (result_bus)
    );

    // shadow configuration
    logic [31:0]        cfg_rest;
    logic [31:0]        cfg_scale;
    logic signed [31:0] cfg_upper;
    logic signed [31:0] cfg_lower;
    logic               cfg_whole;
    logic               cfg_abs;
    logic               cfg_by_fluid;
    logic [16:0]        cfg_fluid_cnt;

    // shadow accumulators
    logic [47:0] density_acc;
    longint      error_sum;
    logic [16:0] above_tally;
    logic [16:0] selected_tally;
    int          nbr_count;

    sdses_pkg::t_result density_reports_q[$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      cycle_count = 0;
    int      stall_left = 0;
    bit      tx_gap_en = 1'b1;
    bit      rx_stall_en = 1'b1;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!rx_stall_en) begin
            result_bus.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            result_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        sdses_pkg::t_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (density_reports_q.size() == 0) begin
                $error("report for particle %0h with none pending", result_bus.result_id);
                mismatch_count++;
            end else begin
                want = density_reports_q.pop_front();
                compare_field("density", want.density, result_bus.density);
                compare_field("result_id", want.result_id, result_bus.result_id);
                compare_field("selected", want.selected, result_bus.selected);
                compare_field("too_low", want.too_low, result_bus.too_low);
                compare_field("error_average", want.error_average, result_bus.error_average);
                compare_field("above_count", want.above_count, result_bus.above_count);
                compare_field("stats_valid", want.stats_valid, result_bus.stats_valid);
                compare_field("divide_fault", want.divide_fault, result_bus.divide_fault);
            end
        end
    end

    function automatic logic [16:0] bump_tally(input logic [16:0] t);
        return (t < sdses_pkg::TALLY_CAP) ? t + 17'd1 : t;
    endfunction

    function automatic void predict_particle_report(input sdses_pkg::t_item it);
        logic [63:0]        prod;
        logic [48:0]        acc_next;
        logic [31:0]        dens;
        logic [31:0]        diff;
        logic [63:0]        mag;
        logic [16:0]        divisor;
        longint             err;
        longint             sum;
        longint             avg;
        longint unsigned    abs_sum;
        longint unsigned    quo;
        logic               at_rest;
        logic               in_win;
        logic               sel;
        logic               fault;
        sdses_pkg::t_result rep;
        if (nbr_count < sdses_pkg::MAX_NEIGHBORS) begin
            prod = 64'(it.kernel_value) * 64'(it.particle_mass);
            acc_next = 49'(density_acc) + 49'(prod[63:16]);
            density_acc = acc_next[48] ? '1 : acc_next[47:0];
            nbr_count++;
        end
        if (!it.last_neighbor) return;
        sel = 1'b0;
        fault = 1'b0;
        avg = 0;
        if (it.is_boundary) begin
            dens = cfg_rest;
        end else begin
            dens = (density_acc > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : density_acc[31:0];
            in_win = ($signed(it.height) < cfg_upper) && ($signed(it.height) > cfg_lower);
            at_rest = dens >= cfg_rest;
            if (in_win && !it.is_floating && !it.is_moving && (cfg_whole || at_rest)) begin
                diff = at_rest ? dens - cfg_rest : cfg_rest - dens;
                mag = (64'(diff) * 64'(cfg_scale) + 64'h0080_0000) >> 24;
                err = (!at_rest && !cfg_abs) ? -longint'(mag) : longint'(mag);
                sum = error_sum + err;
                error_sum = (sum > SUM_HI) ? SUM_HI : (sum < SUM_LO) ? SUM_LO : sum;
                sel = 1'b1;
                selected_tally = bump_tally(selected_tally);
                if (at_rest) above_tally = bump_tally(above_tally);
            end
        end
        rep.density = dens;
        rep.result_id = it.particle_id;
        rep.selected = sel;
        rep.too_low = !sel;
        rep.above_count = above_tally;
        rep.stats_valid = it.last_particle;
        if (it.last_particle) begin
            divisor = cfg_by_fluid ? cfg_fluid_cnt : selected_tally;
            if (divisor == 0) begin
                fault = 1'b1;
            end else begin
                abs_sum = (error_sum < 0) ? -error_sum : error_sum;
                quo = abs_sum / 64'(divisor);
                if (error_sum < 0)
                    avg = (quo > 64'd2147483648) ? -64'sd2147483648 : -longint'(quo);
                else
                    avg = (quo > 64'd2147483647) ? 64'sd2147483647 : longint'(quo);
            end
            error_sum = 0;
            above_tally = '0;
            selected_tally = '0;
        end
        rep.error_average = avg[31:0];
        rep.divide_fault = fault;
        density_acc = '0;
        nbr_count = 0;
        density_reports_q.insert(density_reports_q.size(), rep);
    endfunction

    function automatic sdses_pkg::t_item make_item(input logic [31:0] kern, mass, h,
                                                   input logic bnd, flt, mov,
                                                   input logic [15:0] id,
                                                   input logic ln, lp);
        sdses_pkg::t_item it;
        it.kernel_value = kern;
        it.particle_mass = mass;
        it.height = h;
        it.is_boundary = bnd;
        it.is_floating = flt;
        it.is_moving = mov;
        it.particle_id = id;
        it.last_neighbor = ln;
        it.last_particle = lp;
        return it;
    endfunction

    task automatic send_item(input sdses_pkg::t_item it);
        if (tx_gap_en && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        item_bus.kernel_value = it.kernel_value;
        item_bus.particle_mass = it.particle_mass;
        item_bus.height = it.height;
        item_bus.is_boundary = it.is_boundary;
        item_bus.is_floating = it.is_floating;
        item_bus.is_moving = it.is_moving;
        item_bus.particle_id = it.particle_id;
        item_bus.last_neighbor = it.last_neighbor;
        item_bus.last_particle = it.last_particle;
        item_bus.valid = 1'b1;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        predict_particle_report(it);
        items_sent++;
        @(negedge i_clk);
        item_bus.valid = 1'b0;
    endtask

    task automatic write_reg(input sdses_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            sdses_pkg::CFG_REST_DENSITY:     cfg_rest = data;
            sdses_pkg::CFG_PERCENT_SCALE:    cfg_scale = data;
            sdses_pkg::CFG_UPPER_HEIGHT:     cfg_upper = data;
            sdses_pkg::CFG_LOWER_HEIGHT:     cfg_lower = data;
            sdses_pkg::CFG_WHOLE_FLUID_MODE: cfg_whole = data[0];
            sdses_pkg::CFG_ABS_ERROR_MODE:   cfg_abs = data[0];
            sdses_pkg::CFG_DIVIDE_BY_FLUID:  cfg_by_fluid = data[0];
            sdses_pkg::CFG_FLUID_COUNT:      cfg_fluid_cnt = data[16:0];
            default: ;
        endcase
    endtask

    task automatic drain_reports();
        while (density_reports_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_kernel(input t_kern_style ks, input logic [31:0] mass,
                                                input int n);
        longint unsigned k;
        case (ks)
            K_NEAR_REST: begin
                k = ((64'(cfg_rest) / n) << 16) / ((mass == 0) ? 64'd1 : 64'(mass));
                k = k * (1900 + $urandom_range(0, 200)) / 2000;
                return (k > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : k[31:0];
            end
            K_SMALL: return $urandom_range(0, 255);
            K_MAX:   return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_height();
        longint lo;
        longint hi;
        longint span;
        int     r;
        lo = cfg_lower;
        hi = cfg_upper;
        span = hi - lo - 1;
        r = $urandom_range(0, 9);
        if (r == 0) return cfg_upper;
        if (r == 1) return cfg_lower;
        if (r == 2 || span <= 0) return $urandom;
        return 32'(lo + 1 + longint'($urandom) % span);
    endfunction

    task automatic send_particle(input sdses_pkg::t_item tail, input int n,
                                 input t_kern_style ks);
        sdses_pkg::t_item it;
        int               i;
        for (i = 0; i < n; i++) begin
            it = tail;
            it.last_neighbor = (i == n - 1);
            if (i != n - 1 && $urandom_range(0, 1) == 1) begin
                it.height = $urandom;
                it.is_boundary = $urandom;
                it.is_floating = $urandom;
                it.is_moving = $urandom;
                it.particle_id = $urandom;
                it.last_particle = ($urandom_range(0, 3) == 0);
            end
            it.kernel_value = pick_kernel(ks, it.particle_mass, n);
            send_item(it);
        end
    endtask

    task automatic send_random_particle(input logic last_p);
        sdses_pkg::t_item tail;
        int               n;
        int               r;
        t_kern_style      ks;
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        r = $urandom_range(0, 19);
        ks = (r < 13) ? K_NEAR_REST : (r < 17) ? K_RANDOM : (r < 19) ? K_SMALL : K_MAX;
        tail = make_item(0, $urandom, pick_height(), $urandom_range(0, 9) == 0,
                         $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                         $urandom, 1'b1, last_p);
        if (ks == K_NEAR_REST) tail.particle_mass = $urandom_range(32'h0000_4000, 32'h0004_0000);
        if (ks == K_MAX) tail.particle_mass = 32'hFFFF_FFFF;
        send_particle(tail, n, ks);
    endtask

    task automatic randomize_config();
        logic [31:0]     rest;
        logic [31:0]     scale;
        logic [31:0]     upper;
        logic [31:0]     lower;
        logic [31:0]     fluid;
        longint unsigned ideal;
        case ($urandom_range(0, 4))
            0: rest = sdses_pkg::REST_DENSITY_RST;
            1: rest = 32'h0;
            2: rest = 32'hFFFF_FFFF;
            default: rest = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
        endcase
        ideal = (rest == 0) ? 64'd0 : (64'd100 << 40) / 64'(rest);
        case ($urandom_range(0, 5))
            0: scale = 32'h0;
            1: scale = 32'hFFFF_FFFF;
            2: scale = $urandom;
            default: scale = (rest == 0 || ideal > 64'hFFFF_FFFF) ? $urandom : ideal[31:0];
        endcase
        case ($urandom_range(0, 4))
            0: begin
                upper = sdses_pkg::UPPER_HEIGHT_RST;
                lower = sdses_pkg::LOWER_HEIGHT_RST;
            end
            1: begin
                upper = $urandom;
                lower = $urandom;
            end
            2: begin
                upper = $urandom_range(0, 32'h0100_0000);
                lower = upper;
            end
            default: begin
                upper = $urandom_range(32'h0001_0000, 32'h0400_0000);
                lower = 32'h0 - $urandom_range(32'h0001_0000, 32'h0400_0000);
            end
        endcase
        case ($urandom_range(0, 4))
            0: fluid = 32'h0;
            1: fluid = 32'h1;
            2: fluid = 32'h0001_0000;
            3: fluid = $urandom;
            default: fluid = $urandom_range(1, 400);
        endcase
        write_reg(sdses_pkg::CFG_REST_DENSITY, rest);
        write_reg(sdses_pkg::CFG_PERCENT_SCALE, scale);
        write_reg(sdses_pkg::CFG_UPPER_HEIGHT, upper);
        write_reg(sdses_pkg::CFG_LOWER_HEIGHT, lower);
        write_reg(sdses_pkg::CFG_WHOLE_FLUID_MODE, $urandom);
        write_reg(sdses_pkg::CFG_ABS_ERROR_MODE, $urandom);
        write_reg(sdses_pkg::CFG_DIVIDE_BY_FLUID, $urandom);
        write_reg(sdses_pkg::CFG_FLUID_COUNT, fluid);
    endtask

    task automatic test_reset_defaults();
        send_item(make_item(sdses_pkg::REST_DENSITY_RST, ONE, 0, 0, 0, 0, 16'h0000, 1, 0));
        send_item(make_item(32'h01F4_8000, ONE, 0, 0, 0, 0, 16'hFFFF, 0, 0));
        send_item(make_item(32'h01F4_8000, ONE, 0, 0, 0, 0, 16'hFFFF, 1, 0));
        send_item(make_item(sdses_pkg::REST_DENSITY_RST - 1, ONE, 0, 0, 0, 0, 16'h1234, 1, 1));
    endtask

    task automatic test_window_and_flags();
        logic [31:0] above;
        logic [31:0] half;
        above = sdses_pkg::REST_DENSITY_RST + ONE;
        half = sdses_pkg::REST_DENSITY_RST / 2;
        drain_reports();
        write_reg(sdses_pkg::CFG_UPPER_HEIGHT, 32'h000A_0000);
        write_reg(sdses_pkg::CFG_LOWER_HEIGHT, 32'hFFF6_0000);
        send_item(make_item(32'hFFFF_FFFF, ONE, 0, 1, 0, 0, 16'h0101, 1, 0));
        send_item(make_item(above, ONE, 0, 0, 1, 0, 16'h0102, 1, 0));
        send_item(make_item(above, ONE, 0, 0, 0, 1, 16'h0103, 1, 0));
        send_item(make_item(above, ONE, 32'h000A_0000, 0, 0, 0, 16'h0104, 1, 0));
        send_item(make_item(above, ONE, 32'hFFF6_0000, 0, 0, 0, 16'h0105, 1, 0));
        send_item(make_item(above, ONE, 32'h0009_FFFF, 0, 0, 0, 16'h0106, 1, 0));
        send_item(make_item(above, ONE, 32'hFFF6_0001, 0, 0, 0, 16'h0107, 1, 0));
        send_item(make_item(half, ONE, 0, 0, 0, 0, 16'h0108, 0, 1));
        send_item(make_item(half, ONE, 0, 0, 0, 0, 16'h0108, 1, 0));
        send_item(make_item(0, ONE, 0, 1, 0, 0, 16'h0109, 1, 1));
        send_item(make_item(0, ONE, 0, 1, 0, 0, 16'h010A, 1, 1));
    endtask

    task automatic test_extreme_values();
        drain_reports();
        write_reg(sdses_pkg::CFG_WHOLE_FLUID_MODE, 32'h1);
        write_reg(sdses_pkg::CFG_ABS_ERROR_MODE, 32'h1);
        write_reg(sdses_pkg::CFG_DIVIDE_BY_FLUID, 32'h1);
        write_reg(sdses_pkg::CFG_FLUID_COUNT, 32'h0);
        send_item(make_item('1, '1, 0, 0, 0, 0, 16'h0000, 0, 0));
        send_item(make_item('1, '1, 0, 0, 0, 0, 16'h0000, 1, 0));
        send_item(make_item(0, 0, 0, 0, 0, 0, 16'hFFFF, 1, 0));
        send_item(make_item('1, 0, 32'h7FFF_FFFF, 0, 0, 0, 16'h5555, 1, 0));
        send_item(make_item(0, '1, 32'h8000_0000, 0, 0, 0, 16'hAAAA, 1, 1));
        drain_reports();
        write_reg(sdses_pkg::CFG_ABS_ERROR_MODE, 32'h0);
        write_reg(sdses_pkg::CFG_FLUID_COUNT, 32'h3);
        send_item(make_item(sdses_pkg::REST_DENSITY_RST / 2, ONE, 0, 0, 0, 0, 16'h0F0F, 1, 0));
        send_item(make_item(sdses_pkg::REST_DENSITY_RST / 4, ONE, 0, 0, 0, 0, 16'hF0F0, 1, 1));
    endtask

    task automatic test_error_sum_saturation();
        sdses_pkg::t_item tail;
        int               i;
        drain_reports();
        write_reg(sdses_pkg::CFG_REST_DENSITY, 32'h0);
        write_reg(sdses_pkg::CFG_PERCENT_SCALE, 32'hFFFF_FFFF);
        write_reg(sdses_pkg::CFG_UPPER_HEIGHT, sdses_pkg::UPPER_HEIGHT_RST);
        write_reg(sdses_pkg::CFG_LOWER_HEIGHT, sdses_pkg::LOWER_HEIGHT_RST);
        write_reg(sdses_pkg::CFG_WHOLE_FLUID_MODE, 32'h1);
        write_reg(sdses_pkg::CFG_ABS_ERROR_MODE, 32'h0);
        write_reg(sdses_pkg::CFG_DIVIDE_BY_FLUID, 32'h1);
        write_reg(sdses_pkg::CFG_FLUID_COUNT, 32'h1);
        for (i = 0; i < 160; i++) begin
            tail = make_item(0, '1, pick_height(), 0, 0, 0, $urandom, 1, i == 159);
            send_particle(tail, 1, K_MAX);
        end
        drain_reports();
        write_reg(sdses_pkg::CFG_REST_DENSITY, 32'hFFFF_FFFF);
        for (i = 0; i < 160; i++) begin
            tail = make_item(0, $urandom, pick_height(), 0, 0, 0, $urandom, 1, i == 159);
            send_particle(tail, 1, K_SMALL);
        end
    endtask

    task automatic test_random_passes();
        int phase;
        int phase_end;
        for (phase = 0; phase < 6; phase++) begin
            drain_reports();
            randomize_config();
            tx_gap_en = (phase != 5);
            rx_stall_en = (phase != 5);
            phase_end = items_sent + 185;
            while (items_sent < phase_end) send_random_particle($urandom_range(0, 7) == 0);
            send_random_particle(1'b1);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        item_bus.valid = 1'b0;
        item_bus.kernel_value = '0;
        item_bus.particle_mass = '0;
        item_bus.height = '0;
        item_bus.is_boundary = 1'b0;
        item_bus.is_floating = 1'b0;
        item_bus.is_moving = 1'b0;
        item_bus.particle_id = '0;
        item_bus.last_neighbor = 1'b0;
        item_bus.last_particle = 1'b0;
        result_bus.ready = 1'b0;
        cfg_rest = sdses_pkg::REST_DENSITY_RST;
        cfg_scale = sdses_pkg::PERCENT_SCALE_RST;
        cfg_upper = sdses_pkg::UPPER_HEIGHT_RST;
        cfg_lower = sdses_pkg::LOWER_HEIGHT_RST;
        cfg_whole = 1'b0;
        cfg_abs = 1'b0;
        cfg_by_fluid = 1'b0;
        cfg_fluid_cnt = '0;
        density_acc = '0;
        error_sum = 0;
        above_tally = '0;
        selected_tally = '0;
        nbr_count = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_window_and_flags();
        test_extreme_values();
        test_error_sum_saturation();
        test_random_passes();

        drain_reports();
        if (mismatch_count == 0 && density_reports_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sdses_pkg.sv
rtl/core/sdses_if.sv
rtl/core/sdses_div.sv
rtl/core/sdses_datapath.sv
rtl/core/sdses_ctrl.sv
rtl/core/sph_density_sum_error_stats_unit.sv
tb/tb.sv
